// ----- sv/mtt_pkg.sv -----
package mtt_pkg;

  typedef enum logic [1:0] {
    CMD_SET      = 2'd0,
    CMD_KILL     = 2'd1,
    CMD_KILL_ALL = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_ZERO_REP  = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } sts_code_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EVENT  = 1'b1;

  localparam logic [31:0] REPEAT_FOREVER  = 32'hFFFF_FFFF;
  localparam logic [15:0] TICK_PERIOD_RST = 16'd25;
  localparam logic [5:0]  DIV_LAST_STEP   = 6'd32;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] param;
    logic [31:0] period_ticks;
    logic [31:0] repeats_left;
    logic [31:0] ticks_left;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_FIND_RD,
    S_FIND_CHK,
    S_SET_WR,
    S_REM_RD,
    S_REM_WR,
    S_TICK_RD,
    S_TICK_CHK
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      latch;
    logic      div_start;
    logic      div_step;
    logic      ptr_clr;
    logic      ptr_inc;
    logic      sp_load;
    logic      sp_inc;
    logic      rd_sp;
    logic      wr_set;
    logic      wr_tick;
    logic      wr_shift;
    logic      cnt_clr;
    logic      cnt_dec;
    logic      pend_clr;
    logic      pend_load;
    logic      emit_status;
    sts_code_t status;
    logic      emit_pend;
    logic      emit_last;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_e_t cmd;
    logic   rep_zero;
    logic   div_done;
    logic   at_end;
    logic   full;
    logic   id_match;
    logic   fire;
    logic   fire_remove;
    logic   shift_more;
    logic   pend_valid;
  } dp_sts_t;

endpackage

// ----- sv/mtt_ctrl.sv -----
module mtt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  mtt_pkg::dp_sts_t sts,
  output mtt_pkg::ctl_t   ctl
);
  import mtt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts.cmd)
          CMD_SET:      state_nxt = sts.rep_zero ? S_IDLE : S_DIV;
          CMD_KILL:     state_nxt = S_FIND_RD;
          CMD_KILL_ALL: state_nxt = S_IDLE;
          CMD_TICK:     state_nxt = S_TICK_RD;
          default:      state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_FIND_RD;
      end
      S_FIND_RD: begin
        if (sts.at_end) begin
          state_nxt = (sts.cmd == CMD_SET && !sts.full) ? S_SET_WR : S_IDLE;
        end else begin
          state_nxt = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (sts.id_match) begin
          state_nxt = (sts.cmd == CMD_SET) ? S_SET_WR : S_REM_RD;
        end else begin
          state_nxt = S_FIND_RD;
        end
      end
      S_SET_WR: state_nxt = S_IDLE;
      S_REM_RD: begin
        if (sts.shift_more) begin
          state_nxt = S_REM_WR;
        end else begin
          state_nxt = (sts.cmd == CMD_TICK) ? S_TICK_RD : S_IDLE;
        end
      end
      S_REM_WR: state_nxt = S_REM_RD;
      S_TICK_RD: state_nxt = sts.at_end ? S_IDLE : S_TICK_CHK;
      S_TICK_CHK: state_nxt = sts.fire_remove ? S_REM_RD : S_TICK_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.status = STS_OK;
    unique case (state_r)
      S_IDLE: begin
        ctl.latch = start;
      end
      S_DISPATCH: begin
        unique case (sts.cmd)
          CMD_SET: begin
            if (sts.rep_zero) begin
              ctl.emit_status = 1'b1;
              ctl.status      = STS_ZERO_REP;
            end else begin
              ctl.div_start = 1'b1;
            end
          end
          CMD_KILL: ctl.ptr_clr = 1'b1;
          CMD_KILL_ALL: begin
            ctl.cnt_clr     = 1'b1;
            ctl.emit_status = 1'b1;
          end
          CMD_TICK: begin
            ctl.ptr_clr  = 1'b1;
            ctl.pend_clr = 1'b1;
          end
          default: ;
        endcase
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        ctl.ptr_clr  = sts.div_done;
      end
      S_FIND_RD: begin
        if (sts.at_end) begin
          if (sts.cmd == CMD_SET) begin
            if (sts.full) begin
              ctl.emit_status = 1'b1;
              ctl.status      = STS_FULL;
            end
          end else begin
            ctl.emit_status = 1'b1;
            ctl.status      = STS_NOT_FOUND;
          end
        end
      end
      S_FIND_CHK: begin
        if (sts.id_match) begin
          ctl.sp_load = (sts.cmd == CMD_KILL);
        end else begin
          ctl.ptr_inc = 1'b1;
        end
      end
      S_SET_WR: begin
        ctl.wr_set      = 1'b1;
        ctl.emit_status = 1'b1;
      end
      S_REM_RD: begin
        ctl.rd_sp = 1'b1;
        if (!sts.shift_more) begin
          ctl.cnt_dec     = 1'b1;
          ctl.emit_status = (sts.cmd == CMD_KILL);
        end
      end
      S_REM_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.sp_inc   = 1'b1;
      end
      S_TICK_RD: begin
        if (sts.at_end && sts.pend_valid) begin
          ctl.emit_pend = 1'b1;
          ctl.emit_last = 1'b1;
        end
      end
      S_TICK_CHK: begin
        if (sts.fire) begin
          ctl.pend_load = 1'b1;
          ctl.emit_pend = sts.pend_valid;
        end
        if (sts.fire_remove) begin
          ctl.sp_load = 1'b1;
        end else begin
          ctl.wr_tick = 1'b1;
          ctl.ptr_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/mtt_dp.sv -----
module mtt_dp #(
  parameter int TABLE_DEPTH = 16,
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       in_command,
  input  logic [15:0]      in_timer_id,
  input  logic [31:0]      in_elapse_ms,
  input  logic [31:0]      in_repeat_count,
  input  logic [31:0]      in_bind_param,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_tick_period,
  input  mtt_pkg::ctl_t    ctl,
  output mtt_pkg::dp_sts_t sts,
  output logic             out_strobe,
  output logic             out_kind,
  output logic [1:0]       out_status,
  output logic [15:0]      out_fired_id,
  output logic [31:0]      out_fired_param,
  output logic             out_last,
  output logic [CW-1:0]    active_count
);
  import mtt_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_r;

  cmd_e_t        cmd_r;
  logic [15:0]   id_r;
  logic [31:0]   elapse_r, rep_r, param_r;
  logic [15:0]   tp_r;
  logic [CW-1:0] ptr_r, sp_r, cnt_r;
  logic [32:0]   num_r;
  logic [15:0]   rem_r;
  logic [5:0]    dcnt_r;
  logic          pend_valid_r;
  logic [15:0]   pend_id_r;
  logic [31:0]   pend_param_r;
  logic          out_strobe_r, out_kind_r, out_last_r;
  logic [1:0]    out_status_r;
  logic [15:0]   out_id_r;
  logic [31:0]   out_param_r;

  logic [15:0]   tp_eff;
  logic [16:0]   trial, diff;
  logic          ge;
  logic [31:0]   ticks_val;
  logic [CW-1:0] sp_plus1, raddr;
  logic          we;
  logic [CW-1:0] waddr;
  entry_t        wdata, upd;

  assign tp_eff    = (tp_r == 16'd0) ? 16'd1 : tp_r;
  assign trial     = {rem_r, num_r[32]};
  assign ge        = (trial >= {1'b0, tp_eff});
  assign diff      = trial - {1'b0, tp_eff};
  assign ticks_val = (num_r[31:0] == 32'd0) ? 32'd1 : num_r[31:0];
  assign sp_plus1  = sp_r + CW'(1);
  assign raddr     = ctl.rd_sp ? sp_plus1 : ptr_r;

  // reload or count down the entry just read
  always_comb begin
    upd = rdata_r;
    if (sts.fire) begin
      upd.ticks_left = rdata_r.period_ticks;
      if (rdata_r.repeats_left != REPEAT_FOREVER) begin
        upd.repeats_left = rdata_r.repeats_left - 32'd1;
      end
    end else begin
      upd.ticks_left = rdata_r.ticks_left - 32'd1;
    end
  end

  always_comb begin
    we    = ctl.wr_set | ctl.wr_tick | ctl.wr_shift;
    waddr = ctl.wr_shift ? sp_r : ptr_r;
    if (ctl.wr_set) begin
      wdata = '{id: id_r, param: param_r, period_ticks: ticks_val,
                repeats_left: rep_r, ticks_left: ticks_val};
    end else if (ctl.wr_tick) begin
      wdata = upd;
    end else begin
      wdata = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr[IW-1:0]] <= wdata;
    rdata_r <= mem[raddr[IW-1:0]];
  end

  assign sts.cmd         = cmd_r;
  assign sts.rep_zero    = (rep_r == 32'd0);
  assign sts.div_done    = (dcnt_r == DIV_LAST_STEP);
  assign sts.at_end      = (ptr_r == cnt_r);
  assign sts.full        = (cnt_r == CW'(TABLE_DEPTH));
  assign sts.id_match    = (rdata_r.id == id_r);
  assign sts.fire        = (rdata_r.ticks_left <= 32'd1);
  assign sts.fire_remove = sts.fire && (rdata_r.repeats_left != REPEAT_FOREVER) &&
                           (rdata_r.repeats_left <= 32'd1);
  assign sts.shift_more  = (sp_plus1 < cnt_r);
  assign sts.pend_valid  = pend_valid_r;

  // command latch, divider payload, pending event and output registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r    <= cmd_e_t'(in_command);
      id_r     <= in_timer_id;
      elapse_r <= in_elapse_ms;
      rep_r    <= in_repeat_count;
      param_r  <= in_bind_param;
    end
    if (ctl.div_start) begin
      num_r <= {1'b0, elapse_r} + {17'd0, tp_eff} - 33'd1;
      rem_r <= 16'd0;
    end else if (ctl.div_step) begin
      num_r <= {num_r[31:0], ge};
      rem_r <= ge ? diff[15:0] : trial[15:0];
    end
    if (ctl.pend_load) begin
      pend_id_r    <= rdata_r.id;
      pend_param_r <= rdata_r.param;
    end
    if (ctl.emit_pend) begin
      out_kind_r   <= KIND_EVENT;
      out_status_r <= STS_OK;
      out_id_r     <= pend_id_r;
      out_param_r  <= pend_param_r;
      out_last_r   <= ctl.emit_last;
    end else begin
      out_kind_r   <= KIND_STATUS;
      out_status_r <= ctl.status;
      out_id_r     <= 16'd0;
      out_param_r  <= 32'd0;
      out_last_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r         <= TICK_PERIOD_RST;
      ptr_r        <= '0;
      sp_r         <= '0;
      cnt_r        <= '0;
      dcnt_r       <= '0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) tp_r <= cfg_tick_period;
      if (ctl.ptr_clr) begin
        ptr_r <= '0;
      end else if (ctl.ptr_inc) begin
        ptr_r <= ptr_r + CW'(1);
      end
      if (ctl.sp_load) begin
        sp_r <= ptr_r;
      end else if (ctl.sp_inc) begin
        sp_r <= sp_plus1;
      end
      if (ctl.cnt_clr) begin
        cnt_r <= '0;
      end else if (ctl.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end else if (ctl.wr_set && ptr_r == cnt_r) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (ctl.div_start) begin
        dcnt_r <= '0;
      end else if (ctl.div_step) begin
        dcnt_r <= dcnt_r + 6'd1;
      end
      if (ctl.pend_clr) begin
        pend_valid_r <= 1'b0;
      end else if (ctl.pend_load) begin
        pend_valid_r <= 1'b1;
      end
      out_strobe_r <= ctl.emit_status | ctl.emit_pend;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_fired_id    = out_id_r;
  assign out_fired_param = out_param_r;
  assign out_last        = out_last_r;
  assign active_count    = cnt_r;

endmodule

// ----- sv/multi_timer_table.sv -----
// multi_timer_table: table of software timers driven by commands
// input: a command transfer happens on a clock edge with start high and busy
//   low; in_command selects set, kill, kill all or tick
// config: cfg_tick_period is written on cfg_valid && cfg_ready; cfg_ready is
//   low while a command is in progress
// output: each result sits on the out_ ports for one cycle with out_strobe
//   high; the receiver cannot stall, so every strobe is a transfer
// kill all and a zero-repeat set answer from the dispatch state; set runs a
//   bit-serial divider and then scans the table for its id
// kill scans the table and then compacts it, moving up each entry behind the
//   removed one
// tick visits each active entry and compacts the table for every timer that
//   ends; expiry events come out in table order and the final one carries
//   out_last
// one command at a time: busy stays high until the last result is out
// reset clears the active count and the controller and loads a tick period of
//   25; timer entries need no clearing
module multi_timer_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_timer_id,
  input  logic [31:0] in_elapse_ms,
  input  logic [31:0] in_repeat_count,
  input  logic [31:0] in_bind_param,
  output logic        out_strobe,
  output logic        out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_fired_id,
  output logic [31:0] out_fired_param,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_tick_period
);
  import mtt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ctl_t          ctl;
  dp_sts_t       sts;
  logic [CW-1:0] active_count;

  // config only taken between commands
  assign cfg_ready = ~busy;

  mtt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  mtt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_timer_id     (in_timer_id),
    .in_elapse_ms    (in_elapse_ms),
    .in_repeat_count (in_repeat_count),
    .in_bind_param   (in_bind_param),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_tick_period (cfg_tick_period),
    .ctl             (ctl),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_fired_id    (out_fired_id),
    .out_fired_param (out_fired_param),
    .out_last        (out_last),
    .active_count    (active_count)
  );

  // status results are always the only result of their command
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_STATUS |-> out_last)
    else $error("status result without last");

  a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_EVENT |-> out_status == STS_OK)
    else $error("expiry event with nonzero status");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_count <= CW'(TABLE_DEPTH))
    else $error("active count beyond table depth");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command transfer not followed by busy");

endmodule

// ----- test/multi_timer_table_test.sv -----
`timescale 1ns / 100ps

module multi_timer_table_test;
  import mtt_pkg::*;

  localparam int DEPTH = 16;
  // idle time after the last result before a config write or the end, covers
  // a tick that walks and compacts the table
  localparam int SETTLE_CYCLES = 700;

  typedef struct {
    logic        kind;
    sts_code_t   status;
    logic [15:0] id;
    logic [31:0] param;
    logic        last;
  } timer_result_t;

  // one directed row; has_sts marks a status typed in by hand
  typedef struct {
    cmd_e_t      cmd;
    logic [15:0] id;
    logic [31:0] elapse;
    logic [31:0] repeats;
    logic [31:0] param;
    bit          has_sts;
    sts_code_t   sts;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_TICK;
  logic [15:0] in_timer_id = '0;
  logic [31:0] in_elapse_ms = '0;
  logic [31:0] in_repeat_count = '0;
  logic [31:0] in_bind_param = '0;
  logic        out_strobe;
  logic        out_kind;
  logic [1:0]  out_status;
  logic [15:0] out_fired_id;
  logic [31:0] out_fired_param;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_tick_period = '0;

  // expected results, oldest first
  timer_result_t pending_results[$];
  int            error_count = 0;

  // shadow of the timer table
  logic [15:0] tbl_id[DEPTH];
  logic [31:0] tbl_param[DEPTH];
  logic [31:0] tbl_period[DEPTH];
  logic [31:0] tbl_repeats[DEPTH];
  logic [31:0] tbl_left[DEPTH];
  int          tbl_count = 0;
  logic [15:0] shadow_tick_period = TICK_PERIOD_RST;

  multi_timer_table #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_timer_id(in_timer_id),
    .in_elapse_ms(in_elapse_ms), .in_repeat_count(in_repeat_count),
    .in_bind_param(in_bind_param),
    .out_strobe(out_strobe), .out_kind(out_kind), .out_status(out_status),
    .out_fired_id(out_fired_id), .out_fired_param(out_fired_param),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_tick_period(cfg_tick_period)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void push_status(sts_code_t s);
    timer_result_t r;
    r.kind = KIND_STATUS;
    r.status = s;
    r.id = '0;
    r.param = '0;
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  // close the gap left by a removed timer, keeping activation order
  function automatic void drop_timer(int pos);
    for (int j = pos; j + 1 < tbl_count; j++) begin
      tbl_id[j] = tbl_id[j+1];
      tbl_param[j] = tbl_param[j+1];
      tbl_period[j] = tbl_period[j+1];
      tbl_repeats[j] = tbl_repeats[j+1];
      tbl_left[j] = tbl_left[j+1];
    end
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic int lookup_timer(logic [15:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  // apply one accepted command to the shadow table, queue its results
  function automatic void predict_timers(cmd_e_t cmd, logic [15:0] id, logic [31:0] elapse,
                                         logic [31:0] repeats, logic [31:0] param);
    logic [63:0]   divisor;
    logic [63:0]   ticks;
    int            pos;
    int            i;
    int            fired;
    bit            gone;
    timer_result_t r;
    case (cmd)
      CMD_SET: begin
        if (repeats == 0) begin
          push_status(STS_ZERO_REP);
          return;
        end
        // zero period counts as one, and so does a zero delay
        divisor = (shadow_tick_period == 0) ? 64'd1 : 64'(shadow_tick_period);
        ticks = (64'(elapse) + divisor - 1) / divisor;
        if (ticks == 0) ticks = 1;
        pos = lookup_timer(id);
        if (pos < 0) begin
          if (tbl_count >= DEPTH) begin
            push_status(STS_FULL);
            return;
          end
          pos = tbl_count;
          tbl_count++;
        end
        tbl_id[pos] = id;
        tbl_param[pos] = param;
        tbl_period[pos] = ticks[31:0];
        tbl_repeats[pos] = repeats;
        tbl_left[pos] = ticks[31:0];
        push_status(STS_OK);
      end
      CMD_KILL: begin
        pos = lookup_timer(id);
        if (pos < 0) push_status(STS_NOT_FOUND);
        else begin
          drop_timer(pos);
          push_status(STS_OK);
        end
      end
      CMD_KILL_ALL: begin
        tbl_count = 0;
        push_status(STS_OK);
      end
      default: begin
        i = 0;
        fired = 0;
        while (i < tbl_count) begin
          gone = 0;
          if (tbl_left[i] <= 1) begin
            r.kind = KIND_EVENT;
            r.status = STS_OK;
            r.id = tbl_id[i];
            r.param = tbl_param[i];
            r.last = 1'b0;
            pending_results.push_back(r);
            fired++;
            if (tbl_repeats[i] != REPEAT_FOREVER) begin
              if (tbl_repeats[i] <= 1) begin
                drop_timer(i);
                gone = 1;
              end else tbl_repeats[i]--;
            end
            if (!gone) tbl_left[i] = tbl_period[i];
          end else tbl_left[i]--;
          if (!gone) i++;
        end
        // the final event of the tick carries last
        if (fired > 0) pending_results[pending_results.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  // present one command after a random gap and hold it until the transfer;
  // start is left high so a zero gap next time gives back-to-back commands
  task automatic issue_command(cmd_e_t cmd, logic [15:0] id, logic [31:0] elapse,
                               logic [31:0] repeats, logic [31:0] param);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_timer_id <= id;
    in_elapse_ms <= elapse;
    in_repeat_count <= repeats;
    in_bind_param <= param;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timers(cmd, id, elapse, repeats, param);
  endtask

  // drop start, wait for all results and then the quiet time
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_period(logic [15:0] value);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_tick_period <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_tick_period = value;
  endtask

  // one random command; ids come mostly from a small pool so kills hit and
  // the table fills up
  task automatic random_command();
    int          pick;
    cmd_e_t      cmd;
    logic [15:0] id;
    logic [31:0] elapse;
    logic [31:0] repeats;
    logic [31:0] span;
    pick = $urandom_range(0, 99);
    if (pick < 45) cmd = CMD_TICK;
    else if (pick < 82) cmd = CMD_SET;
    else if (pick < 96) cmd = CMD_KILL;
    else cmd = CMD_KILL_ALL;
    id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
    span = (shadow_tick_period == 0) ? 32'd4 : 32'(shadow_tick_period) * 4;
    if ($urandom_range(0, 9) == 0) elapse = $urandom;
    else elapse = $urandom_range(0, span);
    pick = $urandom_range(0, 19);
    if (pick == 0) repeats = 32'd0;
    else if (pick < 3) repeats = REPEAT_FOREVER;
    else if (pick < 5) repeats = $urandom;
    else repeats = $urandom_range(1, 4);
    issue_command(cmd, id, elapse, repeats, $urandom);
  endtask

  // compare every strobe against the oldest expectation
  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0b status=%0d id=%h param=%h last=%0b",
                 $time, out_kind, out_status, out_fired_id, out_fired_param, out_last);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) begin
          $display("%0t: kind expected %0b actual %0b", $time, want.kind, out_kind);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_fired_id !== want.id) begin
          $display("%0t: fired_id expected %h actual %h", $time, want.id, out_fired_id);
          error_count++;
        end
        if (out_fired_param !== want.param) begin
          $display("%0t: fired_param expected %h actual %h", $time, want.param,
                   out_fired_param);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  cmd_row_t directed_rows[] = '{
    // kill on an empty table, then kill all and an empty tick
    '{CMD_KILL,     16'd5,      32'd0,        32'd1,          32'd0,        1, STS_NOT_FOUND},
    '{CMD_KILL_ALL, 16'd0,      32'd0,        32'd0,          32'd0,        1, STS_OK},
    '{CMD_TICK,     16'd0,      32'd0,        32'd0,          32'd0,        0, STS_OK},
    // zero delay fires on the next tick, one shot
    '{CMD_SET,      16'd0,      32'd0,        32'd1,          32'd0,        1, STS_OK},
    '{CMD_TICK,     16'd0,      32'd0,        32'd0,          32'd0,        0, STS_OK},
    // all-ones fields, repeat forever
    '{CMD_SET,      16'hFFFF,   32'hFFFF_FFFF, REPEAT_FOREVER, 32'hFFFF_FFFF, 1, STS_OK},
    // zero repeat rejected, for a new id and an existing one
    '{CMD_SET,      16'd1,      32'd25,       32'd0,          32'd7,        1, STS_ZERO_REP},
    '{CMD_SET,      16'hFFFF,   32'd25,       32'd0,          32'd7,        1, STS_ZERO_REP},
    // rewrite in place: 26 ms rounds up to two ticks, two firings
    '{CMD_SET,      16'hFFFF,   32'd26,       32'd2,          32'h1234,     1, STS_OK},
    '{CMD_SET,      16'h00A5,   32'd25,       REPEAT_FOREVER, 32'hA5A5_5A5A, 1, STS_OK},
    '{CMD_TICK,     16'd0,      32'd0,        32'd0,          32'd0,        0, STS_OK},
    '{CMD_TICK,     16'd0,      32'd0,        32'd0,          32'd0,        0, STS_OK},
    '{CMD_TICK,     16'd0,      32'd0,        32'd0,          32'd0,        0, STS_OK},
    '{CMD_TICK,     16'd0,      32'd0,        32'd0,          32'd0,        0, STS_OK},
    '{CMD_KILL,     16'h00A5,   32'd0,        32'd0,          32'd0,        1, STS_OK},
    '{CMD_KILL,     16'h00A5,   32'd0,        32'd0,          32'd0,        1, STS_NOT_FOUND},
    '{CMD_KILL_ALL, 16'd0,      32'd0,        32'd0,          32'd0,        1, STS_OK}
  };

  initial begin
    logic [15:0] periods[6];
    periods = '{16'd0, 16'd1, 16'd10, 16'd65535, 16'd100, 16'd25};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; a typed status replaces the predicted one
    foreach (directed_rows[k]) begin
      issue_command(directed_rows[k].cmd, directed_rows[k].id, directed_rows[k].elapse,
                    directed_rows[k].repeats, directed_rows[k].param);
      if (directed_rows[k].has_sts)
        pending_results[pending_results.size()-1].status = directed_rows[k].sts;
    end

    // fill the table, overflow it, then let every timer run out at once
    for (int k = 0; k < DEPTH; k++)
      issue_command(CMD_SET, 16'(100 + k), 32'd1, 32'd2, 32'(k) << 20);
    issue_command(CMD_SET, 16'd999, 32'd1, 32'd1, 32'd0);
    pending_results[pending_results.size()-1].status = STS_FULL;
    issue_command(CMD_TICK, 16'd0, 32'd0, 32'd0, 32'd0);
    issue_command(CMD_TICK, 16'd0, 32'd0, 32'd0, 32'd0);
    issue_command(CMD_TICK, 16'd0, 32'd0, 32'd0, 32'd0);

    // random phases, each under its own tick period
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 5) write_tick_period(periods[phase]);
      else write_tick_period(16'($urandom_range(10, 65535)));
      repeat (49) random_command();
    end

    drain_block();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mtt_pkg.sv
sv/mtt_ctrl.sv
sv/mtt_dp.sv
sv/multi_timer_table.sv
test/multi_timer_table_test.sv
